[design/packed_track_note_decoder_assert.svh]
// ----------------------------------------------------------------------------
// packed track note decoder assertion macros
// concurrent property wrappers clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef PACKED_TRACK_NOTE_DECODER_ASSERT_SVH
`define PACKED_TRACK_NOTE_DECODER_ASSERT_SVH

// same-cycle implication
`define PTND_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptnd same-cycle check failed");

// next-cycle implication
`define PTND_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptnd next-cycle check failed");

`endif

[design/ptnd_pkg.sv]
// ----------------------------------------------------------------------------
// ptnd_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package ptnd_pkg;

	localparam int ROWS_PER_TRACK_DEF = 64;
	localparam int ROW_RESET_VAL      = 64;  // count after reset: track finished
	localparam int BYTE_W             = 8;
	localparam int CHAN_W             = 2;
	localparam int ROW_W              = 6;
	localparam int RUN_W              = 7;   // skip run length up to 64

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 40;

	// row formats from the two top bits of a lead byte
	localparam logic [1:0] KIND_FULL   = 2'b00;
	localparam logic [1:0] KIND_EFFECT = 2'b01;
	localparam logic [1:0] KIND_NOTE   = 2'b10;
	localparam logic [1:0] KIND_SKIP   = 2'b11;

	typedef struct packed {
		logic ready;   // input side may take a word
		logic take;    // input word accepted this cycle
		logic emit;    // put out one empty row of a skip run
		logic in_run;  // controller busy with a skip run
	} ptnd_cmd_t;

	typedef struct packed {
		logic lead_skip;  // incoming word is a live skip lead byte
		logic run_more;   // skip run has rows left inside the track
		logic out_free;   // output register can load this cycle
	} ptnd_status_t;

endpackage

[design/ptnd_ctrl.sv]
// ----------------------------------------------------------------------------
// ptnd_ctrl
// controller: takes bytes, or steps through a run of empty rows
// ----------------------------------------------------------------------------
module ptnd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  ptnd_pkg::ptnd_status_t status,
	output ptnd_pkg::ptnd_cmd_t    cmd
);
	import ptnd_pkg::*;

	localparam logic ST_TAKE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_next;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_TAKE: begin
				cmd.ready = status.out_free;
				cmd.take  = status.out_free && s_tvalid;
				if (cmd.take && status.lead_skip) begin
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.in_run = 1'b1;
				cmd.emit   = status.run_more && status.out_free;
				if (!status.run_more) begin
					state_next = ST_TAKE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

[design/ptnd_datapath.sv]
// ----------------------------------------------------------------------------
// ptnd_datapath
// row counter, cell assembly registers and output register
// ----------------------------------------------------------------------------
module ptnd_datapath #(
	parameter int ROWS_PER_TRACK = ptnd_pkg::ROWS_PER_TRACK_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ptnd_pkg::ptnd_cmd_t                cmd,
	output ptnd_pkg::ptnd_status_t             status,
	input  logic [ptnd_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ptnd_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                              m_tlast
);
	import ptnd_pkg::*;

	localparam int CNT_MIN = (ROWS_PER_TRACK > ROW_RESET_VAL) ? ROWS_PER_TRACK : ROW_RESET_VAL;
	localparam int CNT_W   = $clog2(CNT_MIN + 1);
	localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(ROWS_PER_TRACK);
	localparam logic [CNT_W-1:0] LAST_C = CNT_W'(ROWS_PER_TRACK - 1);
	localparam logic [CNT_W-1:0] RST_C  = CNT_W'(ROW_RESET_VAL);

	logic [BYTE_W-1:0] in_byte;
	logic [CHAN_W-1:0] in_chan;
	assign in_byte = s_tdata[BYTE_W-1:0];
	assign in_chan = s_tdata[BYTE_W +: CHAN_W];

	logic [CNT_W-1:0]  row_q;
	logic [1:0]        pend_q;
	logic [1:0]        kind_q;
	logic [23:0]       held_q;
	logic [CHAN_W-1:0] chan_q;
	logic [RUN_W-1:0]  run_q;

	logic              out_valid_q;
	logic [ROW_W-1:0]  o_row_q;
	logic [CHAN_W-1:0] o_chan_q;
	logic [BYTE_W-1:0] o_b0_q, o_b1_q, o_b2_q, o_b3_q;
	logic              o_done_q;

	logic [CNT_W-1:0] eff_row;
	logic [1:0]       eff_pend;
	logic             live;
	logic [1:0]       lead_kind;
	logic [7:0]       lead_b;
	logic             cell_close;

	assign eff_row    = s_tuser ? '0 : row_q;
	assign eff_pend   = s_tuser ? 2'd0 : pend_q;
	assign live       = eff_row < ROWS_C;
	assign lead_kind  = in_byte[7:6];
	assign lead_b     = held_q[15:8];
	assign cell_close = cmd.take && live && (eff_pend == 2'd1);

	assign status.lead_skip = live && (eff_pend == 2'd0) && (lead_kind == KIND_SKIP);
	assign status.run_more  = (run_q != '0) && (row_q < ROWS_C);
	assign status.out_free  = !out_valid_q || m_tready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= RST_C;
			pend_q      <= 2'd0;
			kind_q      <= KIND_FULL;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cell_close || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.take) begin
				if (s_tuser) begin
					row_q <= '0;
				end
				if (live) begin
					if (eff_pend == 2'd0) begin
						kind_q <= lead_kind;
						unique case (lead_kind)
							KIND_FULL:   pend_q <= 2'd3;
							KIND_EFFECT: pend_q <= 2'd1;
							KIND_NOTE:   pend_q <= 2'd2;
							KIND_SKIP: begin
								pend_q <= 2'd0;
								run_q  <= RUN_W'(in_byte[5:0]) + RUN_W'(1);
							end
						endcase
					end else if (eff_pend > 2'd1) begin
						pend_q <= eff_pend - 2'd1;
					end else begin
						pend_q <= 2'd0;
						row_q  <= eff_row + CNT_W'(1);
					end
				end
			end else if (cmd.emit) begin
				row_q <= row_q + CNT_W'(1);
				run_q <= run_q - RUN_W'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.take && live) begin
			if (eff_pend == 2'd0) begin
				chan_q <= in_chan;
				held_q <= {16'd0, in_byte};
			end else if (eff_pend > 2'd1) begin
				held_q <= {held_q[15:0], in_byte};
			end else begin
				o_row_q  <= eff_row[ROW_W-1:0];
				o_chan_q <= chan_q;
				o_done_q <= eff_row == LAST_C;
				unique case (kind_q)
					KIND_FULL: begin
						o_b0_q <= held_q[23:16];
						o_b1_q <= held_q[15:8];
						o_b2_q <= held_q[7:0];
						o_b3_q <= in_byte;
					end
					KIND_EFFECT: begin
						o_b0_q <= '0;
						o_b1_q <= '0;
						o_b2_q <= {4'h0, held_q[3:0]};
						o_b3_q <= in_byte;
					end
					default: begin
						o_b0_q <= held_q[7:0];
						o_b1_q <= in_byte;
						o_b2_q <= {lead_b[3:0], 4'h0};
						o_b3_q <= '0;
					end
				endcase
			end
		end else if (cmd.emit) begin
			o_row_q  <= row_q[ROW_W-1:0];
			o_chan_q <= chan_q;
			o_done_q <= row_q == LAST_C;
			o_b0_q   <= '0;
			o_b1_q   <= '0;
			o_b2_q   <= '0;
			o_b3_q   <= '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {o_b3_q, o_b2_q, o_b1_q, o_b0_q, o_chan_q, o_row_q};
	assign m_tlast  = o_done_q;

endmodule

[design/packed_track_note_decoder.sv]
// ----------------------------------------------------------------------------
// packed_track_note_decoder
// rebuilds 4-byte note cells from a packed track byte stream
// ----------------------------------------------------------------------------
// usage:
//   input words carry one track byte each; tuser marks the first byte of a
//   track and restarts the row count. output words carry one decoded cell,
//   tlast flags the last row of the track.
//   a cell word is registered from the byte that completes it, and a
//   plain stream of bytes goes in at one word per cycle while the output is free.
//   a skip lead byte holds s_tready low while its empty rows go out, one
//   row per cycle while the receiver takes them, until the run is left.
//   the pace of a run is set by the single output register.
//   after reset the track counts as finished: bytes are dropped until one
//   arrives with tuser set. no memory, no clearing pass.
//   when the receiver stalls, the output word holds and s_tready drops
//   until the word is taken.
// ----------------------------------------------------------------------------
module packed_track_note_decoder #(
	parameter int ROWS_PER_TRACK = ptnd_pkg::ROWS_PER_TRACK_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// byte_value[7:0], channel[9:8], zero [15:10]
	input  logic [ptnd_pkg::S_TDATA_W-1:0] s_tdata,
	// track_start[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// row[5:0], chan_out[7:6], cell_b0[15:8], cell_b1[23:16],
	// cell_b2[31:24], cell_b3[39:32]
	output logic [ptnd_pkg::M_TDATA_W-1:0] m_tdata,
	// track_done
	output logic                          m_tlast
);
	import ptnd_pkg::*;

	`include "packed_track_note_decoder_assert.svh"

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS_PER_TRACK - 1);

	ptnd_cmd_t    cmd;
	ptnd_status_t status;

	// sequencing: byte intake versus empty-row runs
	ptnd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	// row count, cell assembly and output register
	ptnd_datapath #(
		.ROWS_PER_TRACK (ROWS_PER_TRACK)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	assign s_tready = cmd.ready;

	// a stalled output word blocks intake
	`PTND_ASSERT_IMPL(a_stall_blocks_in, m_tvalid && !m_tready, !s_tready)
	// no intake while a skip run is going out
	`PTND_ASSERT_IMPL(a_run_blocks_in, cmd.in_run, !s_tready && !cmd.take)
	// an emitted row shows up as a valid word next cycle
	`PTND_ASSERT_NEXT(a_emit_gives_word, cmd.emit, m_tvalid)
	// last-row flag only on the last row index
	`PTND_ASSERT_IMPL(a_last_row, m_tvalid && m_tlast, m_tdata[ROW_W-1:0] == LAST_ROW)

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for packed_track_note_decoder: a byte-level model of
// the track decoder predicts every note cell from the accepted bytes, and a
// monitor compares each output word against the oldest prediction
// ----------------------------------------------------------------------------
module tb;
	import ptnd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 4;      // margin for the output register and for leaving a run
	localparam int RANDOM_ITEMS = 100;

	// one decoded note cell as it leaves the block
	typedef struct packed {
		logic [5:0] row;
		logic [1:0] chan;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic       last;
	} cell_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;    // byte_value[7:0], channel[9:8], zero [15:10]
	logic                  s_tuser;    // track_start[0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;    // row[5:0], chan_out[7:6], cell_b0..cell_b3 from [15:8] up
	logic                  m_tlast;    // track_done

	// decoder model state
	logic [6:0]  trk_row;
	logic [1:0]  trk_left;
	logic [1:0]  trk_kind;
	logic [23:0] trk_held;
	logic [1:0]  trk_chan;

	cell_t cells_due[$];
	cell_t next_cell;

	bit src_idle;
	bit sink_idle;
	int hold_off;
	int errors;
	int bytes_taken;
	int track_starts;
	int cells_checked;
	int cycles;

	packed_track_note_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d cells outstanding", $time, cells_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// decoder model
	// ------------------------------------------------------------------------

	// queue one cell for the current row and step to the next row
	function automatic void put_cell(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
			logic [7:0] b3);
		cell_t c;
		c.row  = trk_row[5:0];
		c.chan = trk_chan;
		c.b0   = b0;
		c.b1   = b1;
		c.b2   = b2;
		c.b3   = b3;
		c.last = (trk_row == 7'(ROWS_PER_TRACK_DEF - 1));
		cells_due.push_back(c);
		trk_row++;
	endfunction

	// apply one accepted byte to the model, queueing any cells it completes
	function automatic void decode_byte(logic [7:0] b, logic start, logic [1:0] ch);
		int unsigned run;
		if (start) begin
			trk_row  = 7'd0;
			trk_left = 2'd0;    // an open cell is dropped
		end
		// finished track: byte ignored
		if (trk_row >= ROWS_PER_TRACK_DEF)
			return;
		if (trk_left == 2'd0) begin
			// lead byte picks the row format
			trk_chan = ch;
			trk_held = {16'h0000, b};
			trk_kind = b[7:6];
			case (trk_kind)
				KIND_FULL:   trk_left = 2'd3;
				KIND_EFFECT: trk_left = 2'd1;
				KIND_NOTE:   trk_left = 2'd2;
				KIND_SKIP: begin
					// empty rows, clipped at the last row
					run = 32'(b[5:0]) + 32'd1;
					while (run > 0 && trk_row < ROWS_PER_TRACK_DEF) begin
						put_cell(8'h00, 8'h00, 8'h00, 8'h00);
						run--;
					end
				end
			endcase
			return;
		end
		if (trk_left > 2'd1) begin
			trk_held = {trk_held[15:0], b};
			trk_left--;
			return;
		end
		// closing byte of the cell
		trk_left = 2'd0;
		case (trk_kind)
			KIND_FULL:   put_cell(trk_held[23:16], trk_held[15:8], trk_held[7:0], b);
			KIND_EFFECT: put_cell(8'h00, 8'h00, {4'h0, trk_held[3:0]}, b);
			KIND_NOTE:   put_cell(trk_held[7:0], b, {trk_held[11:8], 4'h0}, 8'h00);
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------------

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// compare each taken word with the oldest predicted cell
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (cells_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual %h last %b",
					$time, m_tdata, m_tlast);
			end else begin
				next_cell = cells_due.pop_front();
				cells_checked++;
				check_field("row",        32'(next_cell.row),  32'(m_tdata[5:0]));
				check_field("chan_out",   32'(next_cell.chan), 32'(m_tdata[7:6]));
				check_field("cell_b0",    32'(next_cell.b0),   32'(m_tdata[15:8]));
				check_field("cell_b1",    32'(next_cell.b1),   32'(m_tdata[23:16]));
				check_field("cell_b2",    32'(next_cell.b2),   32'(m_tdata[31:24]));
				check_field("cell_b3",    32'(next_cell.b3),   32'(m_tdata[39:32]));
				check_field("track_done", 32'(next_cell.last), 32'(m_tlast));
			end
		end
	end

	// receiver: random wait per word when sink_idle is set, plus a long hold when asked
	initial begin : receiver
		int gap;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready = 1'b0;
				repeat (hold_off) @(negedge clk);
				hold_off = 0;
			end
			gap = sink_idle ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// ------------------------------------------------------------------------
	// input side; every task is entered and left at a falling edge
	// ------------------------------------------------------------------------

	// offer one byte, wait for the handshake, then feed the model
	task automatic send_byte(input logic [7:0] b, input logic start, input logic [1:0] ch);
		int gap;
		gap = src_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {6'b000000, ch, b};
		s_tuser  = start;
		do @(posedge clk); while (!s_tready);
		decode_byte(b, start, ch);
		bytes_taken++;
		if (start)
			track_starts++;
		@(negedge clk);
	endtask

	// stop offering and let every predicted cell come out
	task automatic drain();
		s_tvalid = 1'b0;
		while (cells_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// after reset the track counts as finished, so plain bytes vanish
	task automatic test_finished_after_reset();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		send_byte(8'h00, 1'b0, 2'd0);
		send_byte(8'hff, 1'b0, 2'd3);
		send_byte(8'hc5, 1'b0, 2'd1);
		drain();
	endtask

	// each row format at the edges of its lead byte and data bytes
	task automatic test_cell_formats();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		// full cells
		send_byte(8'h00, 1'b1, 2'd3);
		send_byte(8'hff, 1'b0, 2'd0);
		send_byte(8'h00, 1'b0, 2'd1);
		send_byte(8'hff, 1'b0, 2'd2);
		send_byte(8'h3f, 1'b0, 2'd0);
		send_byte(8'h80, 1'b0, 2'd3);
		send_byte(8'h7f, 1'b0, 2'd3);
		send_byte(8'h01, 1'b0, 2'd3);
		// effect-only cells
		send_byte(8'h40, 1'b0, 2'd1);
		send_byte(8'hff, 1'b0, 2'd2);
		send_byte(8'h7f, 1'b0, 2'd2);
		send_byte(8'h00, 1'b0, 2'd1);
		// note-only cell
		send_byte(8'hbf, 1'b0, 2'd3);
		send_byte(8'h12, 1'b0, 2'd0);
		send_byte(8'hed, 1'b0, 2'd0);
		// empty-row runs of one and three rows
		send_byte(8'hc0, 1'b0, 2'd2);
		send_byte(8'hc2, 1'b0, 2'd1);
		drain();
	endtask

	// a new track mid-cell drops the open cell; long runs are clipped
	task automatic test_track_restart();
		src_idle  = 1'b0;
		sink_idle = 1'b1;
		send_byte(8'h12, 1'b0, 2'd1);
		send_byte(8'h34, 1'b0, 2'd1);
		// fresh track; the half cell above never comes out
		send_byte(8'h4f, 1'b1, 2'd2);
		send_byte(8'haa, 1'b0, 2'd2);
		// 64 empty rows asked, only 63 fit
		send_byte(8'hff, 1'b0, 2'd0);
		// past the last row: ignored
		send_byte(8'h00, 1'b0, 2'd3);
		send_byte(8'h80, 1'b0, 2'd3);
		drain();
	endtask

	// one track of random well-formed cells with the odd broken cell
	task automatic play_track(inout int sent);
		logic [1:0] ch;
		logic [1:0] kind;
		logic [7:0] lead;
		bit         lead_first;
		int         extra;
		int         keep;
		ch = 2'($urandom_range(0, 3));
		lead_first = 1'b1;
		forever begin
			kind = 2'($urandom_range(0, 3));
			lead = 8'($urandom_range(0, 255));
			lead[7:6] = kind;
			// keep most runs short so tracks hold many cells
			if (kind == KIND_SKIP && $urandom_range(0, 7) != 0)
				lead[5:0] = 6'($urandom_range(0, 5));
			case (kind)
				KIND_FULL:   extra = 3;
				KIND_EFFECT: extra = 1;
				KIND_NOTE:   extra = 2;
				default:     extra = 0;
			endcase
			send_byte(lead, lead_first, ch);
			lead_first = 1'b0;
			sent++;
			keep = extra;
			if (extra > 0 && $urandom_range(0, 24) == 0)
				keep = $urandom_range(0, extra - 1);
			repeat (keep) begin
				send_byte(8'($urandom_range(0, 255)), 1'b0, 2'($urandom_range(0, 3)));
				sent++;
			end
			// a cut cell is left open for the next track start to drop
			if (keep != extra || sent >= RANDOM_ITEMS)
				return;
			if (trk_row >= ROWS_PER_TRACK_DEF)
				break;
			if ($urandom_range(0, 63) == 0)
				return;
		end
		// noise after the last row
		repeat ($urandom_range(0, 2))
			send_byte(8'($urandom_range(0, 255)), 1'b0, 2'($urandom_range(0, 3)));
	endtask

	task automatic test_random_tracks();
		int sent;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			src_idle  = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			play_track(sent);
		end
		drain();
	endtask

	// receiver holds off while bytes keep coming, so the input stalls
	task automatic test_receiver_hold();
		logic [7:0] lead;
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		hold_off  = 300;
		send_byte(8'h00, 1'b1, 2'd2);
		repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0, 2'd2);
		repeat (30) begin
			lead = 8'($urandom_range(0, 255));
			if (lead[7]) begin
				lead[7:6] = KIND_EFFECT;
				send_byte(lead, 1'b0, 2'd2);
				send_byte(8'($urandom_range(0, 255)), 1'b0, 2'd2);
			end else begin
				lead[7:6] = KIND_FULL;
				send_byte(lead, 1'b0, 2'd2);
				repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0, 2'd2);
			end
		end
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		hold_off  = 0;
		// model state after reset: track finished
		trk_row   = 7'(ROW_RESET_VAL);
		trk_left  = 2'd0;
		trk_kind  = KIND_FULL;
		trk_held  = 24'h000000;
		trk_chan  = 2'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_finished_after_reset();
		test_cell_formats();
		test_track_restart();
		test_random_tracks();
		test_receiver_hold();

		$display("%0d track bytes over %0d track starts, %0d cells checked, %0d errors",
			bytes_taken, track_starts, cells_checked, errors);
		$display("all row formats, clipped empty-row runs, dropped cells and a long hold");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/ptnd_pkg.sv
design/ptnd_ctrl.sv
design/ptnd_datapath.sv
design/packed_track_note_decoder.sv
bench/tb.sv
